// ===== rtl/brlce_pkg.sv =====
// Shared types, code values and helpers for the run-length code emitter.
package brlce_pkg;

    // Input item kinds
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Output code values
    localparam logic [3:0] CODE_ZERO_SINGLE = 4'd0;
    localparam logic [3:0] CODE_ZERO_PAIR   = 4'd1;
    localparam logic [3:0] CODE_MARK        = 4'd8;
    localparam logic [3:0] CODE_ONE_SINGLE  = 4'd10;
    localparam logic [3:0] CODE_ONE_PAIR    = 4'd11;

    // Bits encoded per character and codes one item can cause
    localparam int CHAR_BITS  = 7;
    localparam int SLOT_COUNT = 7;
    localparam int SLOT_W     = 3;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_byte;
    } t_req;

    typedef struct packed {
        logic [3:0] code;
        logic       last_of_item;
    } t_res;

    // One classified item: its codes in order, how many, and whether it ends a message
    typedef struct packed {
        logic [SLOT_COUNT-1:0][3:0] codes;
        logic [SLOT_W-1:0]          count;
        logic                       is_end;
    } t_entry;

    // Code of one piece of a run: pair selects weight 2, otherwise weight 1
    function automatic logic [3:0] piece_code(input logic bit_val, input logic pair);
        logic [3:0] c;
        if (bit_val) begin
            c = pair ? CODE_ONE_PAIR : CODE_ONE_SINGLE;
        end else begin
            c = pair ? CODE_ZERO_PAIR : CODE_ZERO_SINGLE;
        end
        return c;
    endfunction

endpackage

// ===== rtl/brlce_front.sv =====
// Front end: accepts requests, tracks the open run and classifies each request into codes.
module brlce_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  brlce_pkg::t_req       i_req,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output brlce_pkg::t_entry     o_entry
);

    logic r_have_bit, n_have_bit;
    logic r_run_bit,  n_run_bit;
    logic r_pending,  n_pending;

    logic [brlce_pkg::SLOT_COUNT-1:0][3:0] codes;
    logic [brlce_pkg::SLOT_W-1:0]          n_codes;
    logic                                  cur_bit;

    assign o_q_push = i_push & ~i_q_full;

    // Walk the character bits MSB first and collect the codes they complete
    always_comb begin
        n_have_bit = r_have_bit;
        n_run_bit  = r_run_bit;
        n_pending  = r_pending;
        n_codes    = '0;
        codes      = '0;
        cur_bit    = 1'b0;
        if (i_req.cmd == brlce_pkg::CMD_CHAR) begin
            for (int b = brlce_pkg::CHAR_BITS - 1; b >= 0; b--) begin
                cur_bit = i_req.char_byte[b];
                if (n_have_bit && (cur_bit == n_run_bit)) begin
                    if (n_pending) begin
                        codes[n_codes] = brlce_pkg::piece_code(n_run_bit, 1'b1);
                        n_codes        = n_codes + 1'b1;
                        n_pending      = 1'b0;
                    end else begin
                        n_pending = 1'b1;
                    end
                end else begin
                    if (n_have_bit && n_pending) begin
                        codes[n_codes] = brlce_pkg::piece_code(n_run_bit, 1'b0);
                        n_codes        = n_codes + 1'b1;
                    end
                    n_have_bit = 1'b1;
                    n_run_bit  = cur_bit;
                    n_pending  = 1'b1;
                end
            end
        end else begin
            // Flush the open single bit, add the marker, rearm
            if (r_have_bit && r_pending) begin
                codes[n_codes] = brlce_pkg::piece_code(r_run_bit, 1'b0);
                n_codes        = n_codes + 1'b1;
            end
            codes[n_codes] = brlce_pkg::CODE_MARK;
            n_codes        = n_codes + 1'b1;
            n_have_bit     = 1'b0;
            n_run_bit      = 1'b0;
            n_pending      = 1'b0;
        end
    end

    assign o_entry.codes  = codes;
    assign o_entry.count  = n_codes;
    assign o_entry.is_end = (i_req.cmd == brlce_pkg::CMD_END);

    // Advance run state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_bit <= 1'b0;
            r_run_bit  <= 1'b0;
            r_pending  <= 1'b0;
        end else if (o_q_push) begin
            r_have_bit <= n_have_bit;
            r_run_bit  <= n_run_bit;
            r_pending  <= n_pending;
        end
    end

endmodule

// ===== rtl/brlce_fifo.sv =====
// Short queue of classified entries between the front and back ends.
module brlce_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  brlce_pkg::t_entry     i_data,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output brlce_pkg::t_entry     o_data
);

    localparam int CNT_W = $clog2(brlce_pkg::FIFO_DEPTH + 1);

    brlce_pkg::t_entry r_mem [brlce_pkg::FIFO_DEPTH];

    logic [brlce_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]              r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(brlce_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Write storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/brlce_back.sv =====
// Back end: emits queued codes one per cycle while results are popped, applies the message limit, holds the result.
module brlce_back #(
    parameter int MAX_CODES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  brlce_pkg::t_entry     i_entry,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output brlce_pkg::t_res       o_res
);

    localparam int CW = $clog2(MAX_CODES + 1);

    logic [CW-1:0]                r_cnt;
    logic [brlce_pkg::SLOT_W-1:0] r_idx;
    logic                         r_out_vld;
    brlce_pkg::t_res              r_res;

    logic head_vld, load_ok, skip, emit, last, done;

    assign head_vld = ~i_q_empty;
    assign load_ok  = ~r_out_vld | i_pop;
    assign skip     = head_vld & ((i_entry.count == '0) | (r_cnt >= CW'(MAX_CODES)));
    assign emit     = head_vld & ~skip & load_ok;
    assign last     = (r_idx == (i_entry.count - 1'b1)) | (r_cnt == CW'(MAX_CODES - 1));
    assign done     = skip | (emit & last);
    assign o_q_pop  = done;

    assign o_empty = ~r_out_vld;
    assign o_res   = r_res;

    // Step through the head entry and keep the message code count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (done) begin
            r_idx <= '0;
            if (i_entry.is_end) begin
                r_cnt <= '0;
            end else if (emit) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Hold the result until popped, refill on the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_ok) begin
            r_out_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res.code         <= i_entry.codes[r_idx];
            r_res.last_of_item <= last;
        end
    end

endmodule

// ===== rtl/binary_run_length_code_emitter_core.sv =====
// Path: a request's codes go from the front into the queue, then one by one into the result
// register, from which they are popped.
// Throughput: one code per cycle while results are popped; a character request causes 3 to 7
// codes, an end request 1 or 2; the front accepts a request per cycle
// while its 4-entry queue has room, so the code emitter sets the sustained rate.
// Reset: synchronous active-low i_rst_n clears run state, message count, queue and result.
module binary_run_length_code_emitter_core #(
    parameter int MAX_CODES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  brlce_pkg::t_req       i_req,
    output logic                  o_empty,
    input  logic                  i_pop,
    output brlce_pkg::t_res       o_res
);

    logic              q_push, q_pop, q_full, q_empty;
    brlce_pkg::t_entry q_in, q_out;

    assign o_full = q_full;

    brlce_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_entry  (q_in)
    );

    brlce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    brlce_back #(
        .MAX_CODES (MAX_CODES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_entry   (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (o_res)
    );

endmodule

// ===== sim/binary_run_length_code_emitter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the run-length code emitter: directed table, then random messages.
module binary_run_length_code_emitter_core_tb;

    localparam int MSG_LIMIT   = 256;
    localparam int RAND_ITEMS  = 155;
    localparam int MAX_GAP     = 18;
    // Quiet stretch of a correct run stays near one gap plus one stall plus the pipeline
    localparam int STALL_LIMIT = 1000;
    localparam int END_WAIT    = 64;

    // One directed request; n_typed < 0 means the predictor supplies the codes
    typedef struct {
        brlce_pkg::t_req req;
        int              n_typed;
        logic [27:0]     codes;     // first code in the low nibble
    } t_dir_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_push;
    logic            o_full;
    brlce_pkg::t_req i_req;
    logic            o_empty;
    logic            i_pop;
    brlce_pkg::t_res o_res;

    // Encoder state of the predictor
    logic        seen_bit;
    logic        run_val;
    logic        half_pair;
    int          msg_codes;
    int          pred_n;
    logic [27:0] pred_word;

    brlce_pkg::t_res pending_codes[$];
    t_dir_row        dir_rows[$];
    brlce_pkg::t_res want;
    int              errors;
    int              sent;
    int              checked;
    int              msgs;
    int              capped_msgs;
    int              quiet;
    int              push_run;
    int              pop_run;

    binary_run_length_code_emitter_core #(
        .MAX_CODES(MSG_LIMIT)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .o_full (o_full),
        .i_req  (i_req),
        .o_empty(o_empty),
        .i_pop  (i_pop),
        .o_res  (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= 20) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Append one code unless the message has reached its limit
    function automatic void emit_code(input logic [3:0] c);
        if (msg_codes < MSG_LIMIT) begin
            msg_codes++;
            pred_word[4*pred_n +: 4] = c;
            pred_n++;
        end
    endfunction

    function automatic void clear_run();
        seen_bit  = 1'b0;
        run_val   = 1'b0;
        half_pair = 1'b0;
        msg_codes = 0;
    endfunction

    // Work out the codes one request causes and advance the encoder state
    function automatic void encode_request(input brlce_pkg::t_req req);
        logic b_val;
        pred_n    = 0;
        pred_word = '0;
        if (req.cmd == brlce_pkg::CMD_CHAR) begin
            for (int b = brlce_pkg::CHAR_BITS - 1; b >= 0; b--) begin
                b_val = req.char_byte[b];
                if (seen_bit && b_val == run_val) begin
                    // close a pair as soon as its second bit arrives
                    if (half_pair) begin
                        emit_code(run_val ? brlce_pkg::CODE_ONE_PAIR
                                          : brlce_pkg::CODE_ZERO_PAIR);
                    end
                    half_pair = !half_pair;
                end else begin
                    // bit change: flush the leftover single of the old run
                    if (seen_bit && half_pair) begin
                        emit_code(run_val ? brlce_pkg::CODE_ONE_SINGLE
                                          : brlce_pkg::CODE_ZERO_SINGLE);
                    end
                    seen_bit  = 1'b1;
                    run_val   = b_val;
                    half_pair = 1'b1;
                end
            end
        end else begin
            if (seen_bit && half_pair) begin
                emit_code(run_val ? brlce_pkg::CODE_ONE_SINGLE : brlce_pkg::CODE_ZERO_SINGLE);
            end
            if (msg_codes >= MSG_LIMIT) capped_msgs++;
            emit_code(brlce_pkg::CODE_MARK);
            msgs++;
            clear_run();
        end
    endfunction

    function automatic int draw_gap(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            run = $urandom_range(8, 20);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic brlce_pkg::t_req make_req(input logic cmd, input logic [7:0] ch);
        brlce_pkg::t_req r;
        r.cmd       = cmd;
        r.char_byte = ch;
        return r;
    endfunction

    function automatic void add_row(input logic cmd, input logic [7:0] ch, input int n,
                                    input logic [27:0] codes);
        t_dir_row row;
        row.req     = make_req(cmd, ch);
        row.n_typed = n;
        row.codes   = codes;
        dir_rows.push_back(row);
    endfunction

    // Send one request after a random gap, then queue its expected codes
    task automatic push_request(input brlce_pkg::t_req req, input int n_typed,
                                input logic [27:0] typed);
        int              gap;
        int              n;
        logic [27:0]     word;
        brlce_pkg::t_res r;
        gap = draw_gap(push_run);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_req  <= req;
        // hold the request until the block takes it
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sent++;
        encode_request(req);
        n    = (n_typed < 0) ? pred_n : n_typed;
        word = (n_typed < 0) ? pred_word : typed;
        for (int k = 0; k < n; k++) begin
            r.code         = word[4*k +: 4];
            r.last_of_item = (k == n - 1);
            pending_codes.push_back(r);
        end
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected code has come out
    task automatic wait_for_drain();
        i_push <= 1'b0;
        @(negedge i_clk);
        while (pending_codes.size() != 0) @(negedge i_clk);
    endtask

    // Mostly alternating bits, so the message runs into the code limit
    task automatic send_long_message(input int len);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            ch    = $urandom_range(0, 1) ? 8'h55 : 8'h2A;
            ch[7] = 1'($urandom_range(0, 1));
            push_request(make_req(brlce_pkg::CMD_CHAR, ch), -1, '0);
        end
        ch = 8'($urandom_range(0, 255));
        push_request(make_req(brlce_pkg::CMD_END, ch), -1, '0);
    endtask

    // Stimulus
    initial begin
        int         len;
        logic [7:0] ch;
        t_dir_row   row;
        i_rst_n = 1'b0;
        i_push  = 1'b0;
        i_pop   = 1'b0;
        i_req   = '0;
        clear_run();

        // empty message: only the marker
        add_row(brlce_pkg::CMD_END,  8'h00, 1, 28'h8);
        // all zeros: three zero pairs, one zero left open
        add_row(brlce_pkg::CMD_CHAR, 8'h00, 3, 28'h111);
        add_row(brlce_pkg::CMD_END,  8'h00, 2, 28'h80);
        // all ones with bit 7 set, which is ignored
        add_row(brlce_pkg::CMD_CHAR, 8'hFF, 3, 28'hBBB);
        add_row(brlce_pkg::CMD_END,  8'hFF, 2, 28'h8A);
        // alternating bits: six singles
        add_row(brlce_pkg::CMD_CHAR, 8'h55, 6, 28'h0A0A0A);
        // keeps alternating across the boundary: seven codes
        add_row(brlce_pkg::CMD_CHAR, 8'h2A, -1, '0);
        add_row(brlce_pkg::CMD_END,  8'h3C, -1, '0);
        // bit 7 alone counts for nothing
        add_row(brlce_pkg::CMD_CHAR, 8'h80, 3, 28'h111);
        add_row(brlce_pkg::CMD_CHAR, 8'h7F, -1, '0);
        add_row(brlce_pkg::CMD_CHAR, 8'h01, -1, '0);
        add_row(brlce_pkg::CMD_CHAR, 8'h40, -1, '0);
        add_row(brlce_pkg::CMD_CHAR, 8'hB3, -1, '0);
        add_row(brlce_pkg::CMD_END,  8'h00, -1, '0);
        add_row(brlce_pkg::CMD_END,  8'h5A, 1, 28'h8);
        add_row(brlce_pkg::CMD_CHAR, 8'h0F, -1, '0);
        add_row(brlce_pkg::CMD_CHAR, 8'hF0, -1, '0);
        add_row(brlce_pkg::CMD_CHAR, 8'hAA, -1, '0);
        add_row(brlce_pkg::CMD_END,  8'hFF, -1, '0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            push_request(row.req, row.n_typed, row.codes);
        end
        wait_for_drain();

        // random messages, the first one long enough to hit the code limit
        send_long_message(46);
        while (sent < dir_rows.size() + RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_long_message($urandom_range(36, 52));
            end else begin
                len = $urandom_range(0, 8);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0) begin
                        ch    = $urandom_range(0, 1) ? 8'h7F : 8'h00;
                        ch[7] = 1'($urandom_range(0, 1));
                    end else begin
                        ch = 8'($urandom_range(0, 255));
                    end
                    push_request(make_req(brlce_pkg::CMD_CHAR, ch), -1, '0);
                end
                ch = 8'($urandom_range(0, 255));
                push_request(make_req(brlce_pkg::CMD_END, ch), -1, '0);
            end
            if ($urandom_range(0, 5) == 0) wait_for_drain();
        end

        wait_for_drain();
        repeat (END_WAIT) @(negedge i_clk);
        $display("Sent %0d requests in %0d messages and checked %0d codes.", sent, msgs, checked);
        $display("%0d messages ran into the %0d-code limit; both sides stalled 0..%0d cycles.",
                 capped_msgs, MSG_LIMIT, MAX_GAP);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result side: pop after a random stall
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_gap(pop_run);
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Check each popped code against the oldest expectation; watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (i_pop && !o_empty) begin
                if (pending_codes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected code %0d", o_res.code));
                end else begin
                    want = pending_codes.pop_front();
                    checked++;
                    if (o_res.code !== want.code) begin
                        flag_mismatch($sformatf("code %0d, expected %0d",
                                                o_res.code, want.code));
                    end
                    if (o_res.last_of_item !== want.last_of_item) begin
                        flag_mismatch($sformatf("last_of_item %0b, expected %0b on code %0d",
                                                o_res.last_of_item, want.last_of_item,
                                                want.code));
                    end
                end
            end
            if (quiet >= STALL_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles, %0d codes outstanding",
                         quiet, pending_codes.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
